[sv/adr_channel_mask_apply_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the channel mask apply unit
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ADR_CHANNEL_MASK_APPLY_UNIT_DEFINES_SVH
`define ADR_CHANNEL_MASK_APPLY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property holds at every clock edge outside reset.
`define ACMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Property never holds at a clock edge outside reset.
`define ACMA_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define ACMA_ASSERT(lbl, prop, msg)
`define ACMA_ASSERT_NEVER(lbl, prop, msg)
`endif

`endif

[sv/acma_pkg.sv]
// ----------------------------------------------------------------------------
// Channel mask apply package
// Beat types, status codes, mask control codes and the slot mapping function.
// ----------------------------------------------------------------------------
package acma_pkg;

  localparam int unsigned JoinSlots  = 3;
  localparam int unsigned BankSize   = 16;
  localparam int unsigned BlockSize  = 8;
  localparam int unsigned BlockBits  = 10;
  localparam int unsigned SlotW      = 7;  // wide enough for any slot up to 80
  localparam int unsigned CfgW       = 5;
  localparam int unsigned CountW     = 5;
  localparam logic [CfgW-1:0] CfgReset = 5'd3;

  localparam logic [2:0] CtrlBlocks = 3'd5;
  localparam logic [2:0] CtrlAllOn  = 3'd6;
  localparam logic [2:0] CtrlRsvd   = 3'd7;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CTRL = 3'd1,
    ST_RSV_BITS = 3'd2,
    ST_NO_BANK  = 3'd3,
    ST_JOIN_OFF = 3'd4,
    ST_NONE_ON  = 3'd5
  } status_e;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  channel_index;
    logic        entry_defined;
    logic        entry_enabled;
    logic [2:0]  mask_control;
    logic [15:0] channel_mask;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [CountW-1:0] active_count;
  } res_t;

  typedef struct packed {
    logic defined;
    logic enabled;
  } flags_t;

  typedef struct packed {
    logic       covered;
    logic [3:0] mbit;
  } slot_map_t;

  // Which mask bit governs a slot under a given control value.
  function automatic slot_map_t slot_map(logic [2:0] ctrl, logic [SlotW-1:0] slot);
    slot_map_t m;
    m.covered = 1'b0;
    m.mbit    = '0;
    if (ctrl == CtrlBlocks) begin
      m.covered = (32'(slot) < BlockBits * BlockSize);
      m.mbit    = slot[6:3];
    end else begin
      m.covered = (slot[SlotW-1:4] == ctrl);
      m.mbit    = slot[3:0];
    end
    return m;
  endfunction

endpackage

[sv/adr_channel_mask_apply_unit.sv]
// ----------------------------------------------------------------------------
// Channel mask apply unit
// Channel table with defined and enabled flags, updated by slot writes and
// by channel mask requests.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  -------------------------------------
//  request   start_i high, busy_o low  req_i  (slot write or mask request)
//  result    res_valid_o, one cycle    res_o  (status, enabled count)
//  config    cfg_valid_i & cfg_ready_o cfg_data_i (channel count)
//
// Each request walks the flag memory over the effective channel count, one
// slot a cycle through its single read port, to commit (when allowed) and to
// count; a mask request that passes the early checks, other than all-on, first
// walks it once more to check for any slot that stays on.
// Reset clears every flag through per-entry valid bits and sets the count to
// three. The result beat cannot be stalled; busy_o falls as it is shown.

`include "adr_channel_mask_apply_unit_defines.svh"

module adr_channel_mask_apply_unit import acma_pkg::*; #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  req_t            req_i,
  output logic            busy_o,
  output logic            res_valid_o,
  output res_t            res_o,
  input  logic            cfg_valid_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output logic            cfg_ready_o
);

  localparam int unsigned AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PtrW  = $clog2(CHANNELS + 1);

  // The check walk looks for any slot that stays on; the main walk commits
  // the new flags (when allowed) and counts the enabled slots.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WALK
  } state_e;

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  logic [CfgW-1:0] cfg_q;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic            pend_q, pend_d;
  logic [PtrW-1:0] pend_slot_q, pend_slot_d;
  logic            modify_q, modify_d;
  logic            any_on_q, any_on_d;
  status_e         status_q, status_d;
  logic [CountW-1:0] tally_q, tally_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;

  logic            accept;
  logic [PtrW-1:0] eff_cnt;
  logic            rd_en;
  flags_t          rd_flags;
  logic            wr_en;
  logic [AddrW-1:0] wr_addr;
  flags_t          wr_data;
  slot_map_t       pm;
  logic            new_en;
  logic            walk_done;
  logic            join_off;
  logic [SlotW-1:0] first_slot;
  slot_map_t       jm;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // The count register may exceed the table size; clip it.
  assign eff_cnt = (32'(cfg_q) < CHANNELS) ? PtrW'(cfg_q) : PtrW'(CHANNELS);

  assign rd_en     = (state_q != S_IDLE) && (ptr_q < eff_cnt);
  assign walk_done = !(ptr_q < eff_cnt) && !pend_q;

  // New enabled flag of the slot whose data has just come back.
  assign pm = slot_map(req_q.mask_control, SlotW'(pend_slot_q));
  always_comb begin
    new_en = rd_flags.enabled;
    if (req_q.mask_control == CtrlAllOn) begin
      new_en = rd_flags.defined | rd_flags.enabled;
    end else if (rd_flags.defined && pm.covered) begin
      new_en = req_q.channel_mask[pm.mbit];
    end
  end

  // Early checks on the incoming request; they need no table data.
  always_comb begin
    join_off   = 1'b0;
    jm         = '0;
    first_slot = (req_i.mask_control == CtrlBlocks) ? '0 : {req_i.mask_control, 4'b0};
    for (int j = 0; j < JoinSlots; j++) begin
      jm = slot_map(req_i.mask_control, SlotW'(j));
      if ((32'(j) < 32'(eff_cnt)) && jm.covered && !req_i.channel_mask[jm.mbit]) begin
        join_off = 1'b1;
      end
    end
  end

  // Memory write: slot write at acceptance, or commit during the main walk.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_slot_q[AddrW-1:0];
    wr_data = '{defined: rd_flags.defined, enabled: new_en};
    if (accept && !req_i.req_type) begin
      wr_en   = (32'(req_i.channel_index) < CHANNELS);
      wr_addr = AddrW'(req_i.channel_index);
      wr_data = '{defined: req_i.entry_defined, enabled: req_i.entry_enabled};
    end else if ((state_q == S_WALK) && pend_q && modify_q) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    ptr_d       = ptr_q;
    pend_d      = rd_en;
    pend_slot_d = ptr_q;
    modify_d    = modify_q;
    any_on_d    = any_on_q;
    status_d    = status_q;
    tally_d     = tally_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (rd_en) begin
      ptr_d = PtrW'(ptr_q + 1'b1);
    end

    unique case (state_q)
      S_IDLE: begin
        pend_d = 1'b0;
        if (accept) begin
          req_d    = req_i;
          ptr_d    = '0;
          tally_d  = '0;
          any_on_d = 1'b0;
          modify_d = 1'b0;
          status_d = ST_OK;
          state_d  = S_WALK;
          if (req_i.req_type) begin
            if (req_i.mask_control == CtrlAllOn) begin
              modify_d = 1'b1;
            end else if (req_i.mask_control == CtrlRsvd) begin
              status_d = ST_BAD_CTRL;
            end else if ((req_i.mask_control == CtrlBlocks) &&
                         (req_i.channel_mask[15:BlockBits] != '0)) begin
              status_d = ST_RSV_BITS;
            end else if (!(32'(first_slot) < 32'(eff_cnt))) begin
              status_d = ST_NO_BANK;
            end else if (join_off) begin
              status_d = ST_JOIN_OFF;
            end else begin
              state_d = S_CHECK;
            end
          end
        end
      end
      S_CHECK: begin
        if (pend_q && rd_flags.defined && new_en) begin
          any_on_d = 1'b1;
        end
        if (walk_done) begin
          ptr_d   = '0;
          state_d = S_WALK;
          if (any_on_q) begin
            modify_d = 1'b1;
          end else begin
            status_d = ST_NONE_ON;
          end
        end
      end
      S_WALK: begin
        if (pend_q && rd_flags.defined && (modify_q ? new_en : rd_flags.enabled)) begin
          tally_d = CountW'(tally_q + 1'b1);
        end
        if (walk_done) begin
          res_valid_d        = 1'b1;
          res_d.status       = status_q;
          res_d.active_count = tally_q;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CfgReset;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      modify_q    <= 1'b0;
      any_on_q    <= 1'b0;
      status_q    <= ST_OK;
      tally_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      modify_q    <= modify_d;
      any_on_q    <= any_on_d;
      status_q    <= status_d;
      tally_q     <= tally_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    pend_slot_q <= pend_slot_d;
    res_q       <= res_d;
  end

  acma_flag_mem #(
    .Depth (CHANNELS),
    .AddrW (AddrW)
  ) u_flag_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q[AddrW-1:0]),
    .rd_data_o (rd_flags)
  );

  // A result beat only ends a walk, and never two in a row.
  `ACMA_ASSERT(a_res_after_walk, res_valid_o |-> $past(state_q == S_WALK), "result without walk")
  `ACMA_ASSERT(a_res_single, res_valid_o |=> !res_valid_o, "result strobe held")
  // Commits only touch slots inside the effective count.
  `ACMA_ASSERT(a_commit_in_range, (wr_en && (state_q == S_WALK)) |-> (pend_slot_q < eff_cnt),
               "commit beyond channel count")
  // A mask commit is only reached with a clean status.
  `ACMA_ASSERT_NEVER(a_commit_status, modify_q && (state_q == S_WALK) && (status_q != ST_OK),
                     "commit on rejected request")

endmodule

[sv/acma_flag_mem.sv]
// ----------------------------------------------------------------------------
// Channel flag memory
// One write and one registered read port; entries never written read as zero.
// ----------------------------------------------------------------------------
module acma_flag_mem import acma_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  flags_t           wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output flags_t           rd_data_o
);

  flags_t           mem_q [Depth];
  logic [Depth-1:0] vld_q;
  flags_t           rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule
